// ----- rtl/core/owbg_pkg.sv -----
// ----------------------------------------------------------------------------
// owbg_pkg
// Shared types and constants for the white-balance gain calibration unit.
// ----------------------------------------------------------------------------
package owbg_pkg;

    localparam int LEVEL_W = 8;
    localparam int GOLD_W  = 12;
    localparam int GAIN_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GOLDEN_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOLDEN_BLUE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GOLDEN_GREEN = 2'd2;

    localparam logic [GOLD_W-1:0] GOLDEN_RED_RST   = 12'd620;
    localparam logic [GOLD_W-1:0] GOLDEN_BLUE_RST  = 12'd719;
    localparam logic [GOLD_W-1:0] GOLDEN_GREEN_RST = 12'd1024;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h0100;

    // Ratio stage widths: measured ratios are 18 bits, golden ratios 22 bits,
    // correction ratios 31 bits, gain quotients 39 bits.
    localparam int CUR_W   = 18;
    localparam int GOLDR_W = 22;
    localparam int CORR_W  = 31;
    localparam int GQ_W    = 39;

    // 0x100 * 512 as a numerator of the final division.
    localparam logic [GQ_W-1:0] UNITY_X_ONE = 39'd131072;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic               green_zero;
    } front_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0] red_gain;
        logic [GAIN_W-1:0] green_gain;
        logic [GAIN_W-1:0] blue_gain;
        logic              apply_ok;
        logic              status;
    } result_t;

    typedef struct packed {
        logic              fault;
        logic              red_ge_one;
        logic              blue_ge_one;
        logic              red_zero;
        logic              blue_zero;
        logic [GAIN_W-1:0] red_half;
        logic [GAIN_W-1:0] blue_half;
    } side_t;

endpackage

// ----- rtl/core/otp_white_balance_gain_unit.sv -----
// ----------------------------------------------------------------------------
// otp_white_balance_gain_unit
// White-balance gain calibration of one camera module against golden ratios.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  -------   ----------------   ----------------------------------------------
//  input     push / full        red, blue, green_red, green_blue levels
//  result    empty / pop        red, green, blue gains, apply_ok, status
//  config    cfg_we (no wait)   cfg_index, cfg_data (golden red, blue, green)
//
// One beat is accepted per cycle and one result leaves per cycle in steady
// state, while the result queue is not full. A beat passes from acceptance
// through the middle queue, then three rounds of bit-per-stage dividers (22,
// 31 and 39 stages) into the result queue; it can be popped from the next cycle on.
// The whole divider pipeline stalls together only when the result queue is
// full; the input queue then fills and raises full. Reset clears the queues,
// the pipeline valid bits and loads the golden registers with their defaults.
//
module otp_white_balance_gain_unit #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [owbg_pkg::LEVEL_W-1:0]   red_level,
    input  logic [owbg_pkg::LEVEL_W-1:0]   blue_level,
    input  logic [owbg_pkg::LEVEL_W-1:0]   green_red_level,
    input  logic [owbg_pkg::LEVEL_W-1:0]   green_blue_level,
    output logic                           empty,
    input  logic                           pop,
    output logic [owbg_pkg::GAIN_W-1:0]    red_gain,
    output logic [owbg_pkg::GAIN_W-1:0]    green_gain,
    output logic [owbg_pkg::GAIN_W-1:0]    blue_gain,
    output logic                           apply_ok,
    output logic                           status,
    input  logic                           cfg_we,
    input  logic [owbg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [owbg_pkg::GOLD_W-1:0]    cfg_data
);
    import owbg_pkg::*;

    logic [GOLD_W-1:0] golden_red_reg;
    logic [GOLD_W-1:0] golden_blue_reg;
    logic [GOLD_W-1:0] golden_green_reg;

    front_item_t front_item;
    front_item_t mid_item;
    logic        mid_empty;
    logic        mid_pop;
    logic        out_full;
    logic        back_valid;
    logic        back_push;
    result_t     back_result;
    result_t     out_result;

    // Golden registers; writes to an unknown index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            golden_red_reg   <= GOLDEN_RED_RST;
            golden_blue_reg  <= GOLDEN_BLUE_RST;
            golden_green_reg <= GOLDEN_GREEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GOLDEN_RED:   golden_red_reg   <= cfg_data;
                REG_GOLDEN_BLUE:  golden_blue_reg  <= cfg_data;
                REG_GOLDEN_GREEN: golden_green_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // The front classifies each beat as it arrives.
    owbg_front u_front (
        .red_level        (red_level),
        .blue_level       (blue_level),
        .green_red_level  (green_red_level),
        .green_blue_level (green_blue_level),
        .item             (front_item)
    );

    // The middle queue decouples acceptance from the divider pipeline.
    owbg_queue #(.W($bits(front_item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_item),
        .empty (mid_empty)
    );

    owbg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (!out_full),
        .in_valid     (!mid_empty),
        .in_item      (mid_item),
        .in_pop       (mid_pop),
        .golden_red   (golden_red_reg),
        .golden_blue  (golden_blue_reg),
        .golden_green (golden_green_reg),
        .out_valid    (back_valid),
        .out_result   (back_result)
    );

    assign back_push = back_valid && !out_full;

    // The result queue holds finished results until they are popped.
    owbg_queue #(.W($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_push),
        .wdata (back_result),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_result),
        .empty (empty)
    );

    assign red_gain   = out_result.red_gain;
    assign green_gain = out_result.green_gain;
    assign blue_gain  = out_result.blue_gain;
    assign apply_ok   = out_result.apply_ok;
    assign status     = out_result.status;

    // A faulted result carries zero gains and never asks to be applied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status) |-> (red_gain == '0 && green_gain == '0 &&
                                blue_gain == '0 && !apply_ok))
        else $error("faulted result has nonzero gains");

    // apply_ok tracks the three gains exactly.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (apply_ok == (red_gain != '0 && green_gain != '0 &&
                                 blue_gain != '0)))
        else $error("apply_ok disagrees with gains");

    // A finished result is never dropped: the pipeline holds while the
    // result queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (back_valid && out_full) |=> back_valid)
        else $error("result lost at the result queue");
endmodule

// ----- rtl/core/owbg_queue.sv -----
// ----------------------------------------------------------------------------
// owbg_queue
// Small synchronous queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module owbg_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ----- rtl/core/owbg_div.sv -----
// ----------------------------------------------------------------------------
// owbg_div
// Pipelined restoring divider, one quotient bit per stage, NW stages.
// ----------------------------------------------------------------------------
module owbg_div #(
    parameter int NW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);
    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] acc_reg [NW];
    logic [DW-1:0] den_reg [NW];

    for (genvar s = 0; s < NW; s++)
    begin : g_step
        logic [DW-1:0] rem_in;
        logic [NW-1:0] acc_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic          take;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign acc_in = num;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign acc_in = acc_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        // The quotient bits shift in from the right as numerator bits leave.
        assign trial = {rem_in, acc_in[NW-1]};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
                acc_reg[s] <= {acc_in[NW-2:0], take};
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = acc_reg[NW-1];
endmodule

// ----- rtl/core/owbg_front.sv -----
// ----------------------------------------------------------------------------
// owbg_front
// Front end: averages the greens and flags a zero green average.
// ----------------------------------------------------------------------------
module owbg_front (
    input  logic [owbg_pkg::LEVEL_W-1:0] red_level,
    input  logic [owbg_pkg::LEVEL_W-1:0] blue_level,
    input  logic [owbg_pkg::LEVEL_W-1:0] green_red_level,
    input  logic [owbg_pkg::LEVEL_W-1:0] green_blue_level,
    output owbg_pkg::front_item_t         item
);
    import owbg_pkg::*;

    logic [LEVEL_W:0] green_sum;

    assign green_sum       = {1'b0, green_red_level} + {1'b0, green_blue_level};
    assign item.red        = red_level;
    assign item.blue       = blue_level;
    assign item.green      = green_sum[LEVEL_W:1];
    assign item.green_zero = (green_sum[LEVEL_W:1] == '0);
endmodule

// ----- rtl/core/owbg_back.sv -----
// ----------------------------------------------------------------------------
// owbg_back
// Back end: three rounds of pipelined division and the gain selection.
// ----------------------------------------------------------------------------
module owbg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  owbg_pkg::front_item_t       in_item,
    output logic                        in_pop,
    input  logic [owbg_pkg::GOLD_W-1:0] golden_red,
    input  logic [owbg_pkg::GOLD_W-1:0] golden_blue,
    input  logic [owbg_pkg::GOLD_W-1:0] golden_green,
    output logic                        out_valid,
    output owbg_pkg::result_t           out_result
);
    import owbg_pkg::*;

    localparam int L1 = GOLDR_W;
    localparam int L2 = CORR_W;
    localparam int L3 = GQ_W;

    logic            take;
    logic [L1-1:0]   v1_reg;
    logic [L2-1:0]   v2_reg;
    logic [L3-1:0]   v3_reg;
    logic [L1-1:0]   f1_reg;
    logic [L2-1:0]   f2_reg;
    side_t           s3_reg [L3];

    logic [GOLDR_W-1:0] q_cur_rg, q_cur_bg, q_gold_rg, q_gold_bg;
    logic [CORR_W-1:0]  q_rr, q_br;
    logic [GQ_W-1:0]    q_gr, q_gb, q_b_over_r, q_r_over_b;
    logic               fault1, fault2;
    side_t              side_in, sd;
    logic               fault_c, red_unity;
    logic [GAIN_W-1:0]  rg, gg, bg;

    assign take   = adv && in_valid;
    assign in_pop = take;

    // Round one: measured and golden ratios scaled by 1024.
    owbg_div #(.NW(GOLDR_W), .DW(LEVEL_W)) u_cur_rg (
        .clk(clk), .en(adv),
        .num({(GOLDR_W - LEVEL_W - 10)'(0), in_item.red, 10'd0}),
        .den(in_item.green), .quo(q_cur_rg));
    owbg_div #(.NW(GOLDR_W), .DW(LEVEL_W)) u_cur_bg (
        .clk(clk), .en(adv),
        .num({(GOLDR_W - LEVEL_W - 10)'(0), in_item.blue, 10'd0}),
        .den(in_item.green), .quo(q_cur_bg));
    owbg_div #(.NW(GOLDR_W), .DW(GOLD_W)) u_gold_rg (
        .clk(clk), .en(adv), .num({golden_red, 10'd0}),
        .den(golden_green), .quo(q_gold_rg));
    owbg_div #(.NW(GOLDR_W), .DW(GOLD_W)) u_gold_bg (
        .clk(clk), .en(adv), .num({golden_blue, 10'd0}),
        .den(golden_green), .quo(q_gold_bg));

    assign fault1 = f1_reg[L1-1] || (q_cur_rg == '0) || (q_cur_bg == '0);

    // Round two: correction ratios scaled by 512.
    owbg_div #(.NW(CORR_W), .DW(CUR_W)) u_rr (
        .clk(clk), .en(adv), .num({q_gold_rg, 9'd0}),
        .den(q_cur_rg[CUR_W-1:0]), .quo(q_rr));
    owbg_div #(.NW(CORR_W), .DW(CUR_W)) u_br (
        .clk(clk), .en(adv), .num({q_gold_bg, 9'd0}),
        .den(q_cur_bg[CUR_W-1:0]), .quo(q_br));

    assign fault2 = f2_reg[L2-1];

    // Round three: every gain quotient any branch may need.
    owbg_div #(.NW(GQ_W), .DW(CORR_W)) u_gr (
        .clk(clk), .en(adv), .num(UNITY_X_ONE), .den(q_rr), .quo(q_gr));
    owbg_div #(.NW(GQ_W), .DW(CORR_W)) u_gb (
        .clk(clk), .en(adv), .num(UNITY_X_ONE), .den(q_br), .quo(q_gb));
    owbg_div #(.NW(GQ_W), .DW(CORR_W)) u_b_over_r (
        .clk(clk), .en(adv), .num({q_br, 8'd0}), .den(q_rr), .quo(q_b_over_r));
    owbg_div #(.NW(GQ_W), .DW(CORR_W)) u_r_over_b (
        .clk(clk), .en(adv), .num({q_rr, 8'd0}), .den(q_br), .quo(q_r_over_b));

    assign side_in.fault       = fault2;
    assign side_in.red_ge_one  = (q_rr >= CORR_W'(512));
    assign side_in.blue_ge_one = (q_br >= CORR_W'(512));
    assign side_in.red_zero    = (q_rr == '0);
    assign side_in.blue_zero   = (q_br == '0);
    assign side_in.red_half    = q_rr[GAIN_W:1];
    assign side_in.blue_half   = q_br[GAIN_W:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= '0;
            v2_reg <= '0;
            v3_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg <= {v1_reg[L1-2:0], take};
            v2_reg <= {v2_reg[L2-2:0], v1_reg[L1-1]};
            v3_reg <= {v3_reg[L3-2:0], v2_reg[L2-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg    <= {f1_reg[L1-2:0], in_item.green_zero || (golden_green == '0)};
            f2_reg    <= {f2_reg[L2-2:0], fault1};
            s3_reg[0] <= side_in;
            for (int i = 1; i < L3; i++)
            begin
                s3_reg[i] <= s3_reg[i-1];
            end
        end
    end

    assign sd = s3_reg[L3-1];

    always_comb
    begin
        fault_c   = sd.fault;
        red_unity = 1'b0;
        rg        = '0;
        gg        = '0;
        bg        = '0;
        if (!fault_c)
        begin
            if (sd.red_ge_one && sd.blue_ge_one)
            begin
                rg = sd.red_half;
                gg = UNITY_GAIN;
                bg = sd.blue_half;
            end
            else
            begin
                priority if (sd.red_ge_one)
                begin
                    red_unity = 1'b0;
                end
                else if (sd.blue_ge_one)
                begin
                    red_unity = 1'b1;
                end
                else if (sd.red_zero || sd.blue_zero)
                begin
                    fault_c = 1'b1;
                end
                else
                begin
                    red_unity = (q_gr[GAIN_W-1:0] >= q_gb[GAIN_W-1:0]);
                end
                // The ratio that divides in the chosen branch must not be zero.
                if (red_unity ? sd.red_zero : sd.blue_zero)
                begin
                    fault_c = 1'b1;
                end
                if (!fault_c)
                begin
                    if (red_unity)
                    begin
                        rg = UNITY_GAIN;
                        gg = q_gr[GAIN_W-1:0];
                        bg = q_b_over_r[GAIN_W-1:0];
                    end
                    else
                    begin
                        rg = q_r_over_b[GAIN_W-1:0];
                        gg = q_gb[GAIN_W-1:0];
                        bg = UNITY_GAIN;
                    end
                end
            end
        end
        if (fault_c)
        begin
            rg = '0;
            gg = '0;
            bg = '0;
        end
    end

    assign out_valid             = v3_reg[L3-1];
    assign out_result.red_gain   = rg;
    assign out_result.green_gain = gg;
    assign out_result.blue_gain  = bg;
    assign out_result.apply_ok   = (rg != '0) && (gg != '0) && (bg != '0);
    assign out_result.status     = fault_c;
endmodule

// ----- test/otp_white_balance_gain_unit_tb.sv -----
// ----------------------------------------------------------------------------
// otp_white_balance_gain_unit_tb
// Self-checking bench for the white-balance gain calibration unit.
// ----------------------------------------------------------------------------
// Calibration beats are pushed through the unit under several golden register
// settings. A scoreboard predicts the gains, apply flag and status of each
// accepted beat and compares them in order with the popped results. Both
// sides idle at random, and the result side holds off once for a long
// stretch so that the unit fills and stalls its input.
// ----------------------------------------------------------------------------
module otp_white_balance_gain_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import owbg_pkg::*;

    // The index space has one slot with no register behind it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 120;

    // ------------------------------------------------------------------------
    // Scoreboard: a copy of the golden registers and a queue of expected
    // results, one per accepted calibration beat.
    // ------------------------------------------------------------------------
    class gain_scoreboard;
        logic [GOLD_W-1:0] gold_red;
        logic [GOLD_W-1:0] gold_blue;
        logic [GOLD_W-1:0] gold_green;
        result_t           expected_gains[$];
        int                errors;
        int                beats_in;
        int                beats_out;
        int                faults_seen;

        function new();
            gold_red    = GOLDEN_RED_RST;
            gold_blue   = GOLDEN_BLUE_RST;
            gold_green  = GOLDEN_GREEN_RST;
            errors      = 0;
            beats_in    = 0;
            beats_out   = 0;
            faults_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GOLD_W-1:0] data);
            case (idx)
                REG_GOLDEN_RED:   gold_red   = data;
                REG_GOLDEN_BLUE:  gold_blue  = data;
                REG_GOLDEN_GREEN: gold_green = data;
                default: ;
            endcase
        endfunction

        // Golden-ratio gain computation with exact intermediates.
        function result_t calc_gains(logic [7:0] r, logic [7:0] b,
                                     logic [7:0] gr, logic [7:0] gb);
            longint unsigned g, cur_rg, cur_bg, gold_rg, gold_bg, rr, br;
            longint unsigned rg, gg, bg, q_r, q_b;
            logic            fault;
            logic            red_unity;
            result_t         res;
            g = (longint'(gr) + longint'(gb)) >> 1;
            rg = 0;
            gg = 0;
            bg = 0;
            fault = 1'b0;
            red_unity = 1'b0;
            if (g == 0 || gold_green == 0)
            begin
                fault = 1'b1;
            end
            else
            begin
                cur_rg  = longint'(r) * 1024 / g;
                cur_bg  = longint'(b) * 1024 / g;
                gold_rg = 1024 * longint'(gold_red) / longint'(gold_green);
                gold_bg = 1024 * longint'(gold_blue) / longint'(gold_green);
                if (cur_rg == 0 || cur_bg == 0)
                begin
                    fault = 1'b1;
                end
                else
                begin
                    rr = 512 * gold_rg / cur_rg;
                    br = 512 * gold_bg / cur_bg;
                    if (rr >= 512 && br >= 512)
                    begin
                        rg = (256 * rr / 512) & 16'hFFFF;
                        gg = 256;
                        bg = (256 * br / 512) & 16'hFFFF;
                    end
                    else
                    begin
                        // Pick the channel held at unity; when both ratios
                        // are below one, the larger green gain decides.
                        if (rr >= 512)
                        begin
                            red_unity = 1'b0;
                        end
                        else if (br >= 512)
                        begin
                            red_unity = 1'b1;
                        end
                        else if (rr == 0 || br == 0)
                        begin
                            fault = 1'b1;
                        end
                        else
                        begin
                            q_r = (256 * 512 / rr) & 16'hFFFF;
                            q_b = (256 * 512 / br) & 16'hFFFF;
                            red_unity = (q_r >= q_b);
                        end
                        if (!fault)
                        begin
                            if (red_unity)
                            begin
                                if (rr == 0)
                                begin
                                    fault = 1'b1;
                                end
                                else
                                begin
                                    rg = 256;
                                    gg = (256 * 512 / rr) & 16'hFFFF;
                                    bg = (256 * br / rr) & 16'hFFFF;
                                end
                            end
                            else
                            begin
                                if (br == 0)
                                begin
                                    fault = 1'b1;
                                end
                                else
                                begin
                                    rg = (256 * rr / br) & 16'hFFFF;
                                    gg = (256 * 512 / br) & 16'hFFFF;
                                    bg = 256;
                                end
                            end
                        end
                    end
                end
            end
            if (fault)
            begin
                rg = 0;
                gg = 0;
                bg = 0;
            end
            res.red_gain   = rg[GAIN_W-1:0];
            res.green_gain = gg[GAIN_W-1:0];
            res.blue_gain  = bg[GAIN_W-1:0];
            res.apply_ok   = (rg != 0 && gg != 0 && bg != 0);
            res.status     = fault;
            return res;
        endfunction

        function void note_beat(logic [7:0] r, logic [7:0] b,
                                logic [7:0] gr, logic [7:0] gb);
            expected_gains.push_back(calc_gains(r, b, gr, gb));
            beats_in++;
        endfunction

        function void check_beat(result_t got);
            result_t want;
            if (expected_gains.size() == 0)
            begin
                $error("Result beat with no expectation pending");
                errors++;
                return;
            end
            want = expected_gains.pop_front();
            beats_out++;
            if (want.status) faults_seen++;
            if (got.red_gain !== want.red_gain)
            begin
                $error("red_gain expected %0h got %0h", want.red_gain, got.red_gain);
                errors++;
            end
            if (got.green_gain !== want.green_gain)
            begin
                $error("green_gain expected %0h got %0h", want.green_gain, got.green_gain);
                errors++;
            end
            if (got.blue_gain !== want.blue_gain)
            begin
                $error("blue_gain expected %0h got %0h", want.blue_gain, got.blue_gain);
                errors++;
            end
            if (got.apply_ok !== want.apply_ok)
            begin
                $error("apply_ok expected %0b got %0b", want.apply_ok, got.apply_ok);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status expected %0b got %0b", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [LEVEL_W-1:0]   red_level = '0;
    logic [LEVEL_W-1:0]   blue_level = '0;
    logic [LEVEL_W-1:0]   green_red_level = '0;
    logic [LEVEL_W-1:0]   green_blue_level = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [GAIN_W-1:0]    red_gain;
    logic [GAIN_W-1:0]    green_gain;
    logic [GAIN_W-1:0]    blue_gain;
    logic                 apply_ok;
    logic                 status;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GOLD_W-1:0]    cfg_data = '0;

    gain_scoreboard sb = new();

    // Idling is turned off for the last stretch; the long hold-off is
    // requested once by the stimulus and served by the receiver.
    bit quiet_tail = 1'b0;
    bit hold_request = 1'b0;

    otp_white_balance_gain_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .red_level        (red_level),
        .blue_level       (blue_level),
        .green_red_level  (green_red_level),
        .green_blue_level (green_blue_level),
        .empty            (empty),
        .pop              (pop),
        .red_gain         (red_gain),
        .green_gain       (green_gain),
        .blue_gain        (blue_gain),
        .apply_ok         (apply_ok),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // A fixed wall far beyond the slowest correct run.
    initial
    begin
        #4ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, before the
    // nonblocking updates of that edge land, so it sees what the unit sees.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (cfg_we) sb.write_reg(cfg_index, cfg_data);
            if (push && !full)
                sb.note_beat(red_level, blue_level, green_red_level, green_blue_level);
            if (pop && !empty)
            begin
                got.red_gain   = red_gain;
                got.green_gain = green_gain;
                got.blue_gain  = blue_gain;
                got.apply_ok   = apply_ok;
                got.status     = status;
                sb.check_beat(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: pops in random bursts with random stalls between them, and
    // once holds off for a long stretch while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (400) @(posedge clk);
            end
            n = $urandom_range(1, 30);
            pop <= 1'b1;
            repeat (n) @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 2) != 0)
            begin
                n = $urandom_range(1, 13);
                pop <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks.
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] r, input logic [7:0] b,
                             input logic [7:0] gr, input logic [7:0] gb);
        int gap;
        push             <= 1'b1;
        red_level        <= r;
        blue_level       <= b;
        green_red_level  <= gr;
        green_blue_level <= gb;
        @(posedge clk);
        while (full) @(posedge clk);
        // Gaps come in bursts; push stays high for back-to-back beats.
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic end_burst();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GOLD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_golden(input logic [GOLD_W-1:0] gred, input logic [GOLD_W-1:0] gblue,
                              input logic [GOLD_W-1:0] ggreen);
        write_reg(REG_GOLDEN_RED, gred);
        write_reg(REG_GOLDEN_BLUE, gblue);
        write_reg(REG_GOLDEN_GREEN, ggreen);
        @(posedge clk);
    endtask

    // Registers are only touched once every pending result has come back.
    task automatic wait_idle();
        end_burst();
        while (sb.expected_gains.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly plausible module readings with random content; a share of
    // noise with zero bytes and full-range values.
    task automatic random_beats(input int count);
        logic [7:0] r, b, gr, gb;
        int         base;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                r  = 8'($urandom_range(0, 255));
                b  = 8'($urandom_range(0, 255));
                gr = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
                gb = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
            end
            else
            begin
                base = $urandom_range(1, 255);
                gr = 8'(base);
                gb = 8'($urandom_range(base > 20 ? base - 20 : 1, base < 235 ? base + 20 : 255));
                r  = 8'($urandom_range(1, 255));
                b  = 8'($urandom_range(1, 255));
            end
            send_beat(r, b, gr, gb);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at the reset golden values: zero green average,
        // zero measured ratios, byte extremes, and readings that land in
        // each of the gain branches.
        send_beat(8'd0,   8'd0,   8'd0,   8'd0);
        send_beat(8'd100, 8'd100, 8'd1,   8'd0);
        send_beat(8'd255, 8'd255, 8'd255, 8'd255);
        send_beat(8'd0,   8'd50,  8'd60,  8'd60);
        send_beat(8'd50,  8'd0,   8'd60,  8'd60);
        send_beat(8'd1,   8'd255, 8'd255, 8'd255);
        send_beat(8'd1,   8'd1,   8'd255, 8'd255);
        send_beat(8'd255, 8'd255, 8'd1,   8'd1);
        send_beat(8'd255, 8'd10,  8'd40,  8'd40);
        send_beat(8'd10,  8'd255, 8'd40,  8'd40);
        send_beat(8'd60,  8'd70,  8'd100, 8'd101);
        send_beat(8'd170, 8'd85,  8'd170, 8'd85);
        send_beat(8'd85,  8'd170, 8'd85,  8'd170);
        wait_idle();

        // Golden ratios at their extremes: huge ratios push gains past
        // 16 bits, zero golden ratios force zero correction ratios.
        set_golden(12'd4095, 12'd4095, 12'd1);
        send_beat(8'd1,   8'd1,   8'd255, 8'd255);
        send_beat(8'd255, 8'd255, 8'd1,   8'd1);
        send_beat(8'd128, 8'd64,  8'd32,  8'd16);
        random_beats(60);
        wait_idle();

        set_golden(12'd0, 12'd0, 12'd4095);
        send_beat(8'd10,  8'd10,  8'd10,  8'd10);
        send_beat(8'd255, 8'd255, 8'd255, 8'd255);
        random_beats(40);
        wait_idle();

        // A write to the unused index must leave the golden values alone.
        set_golden(12'd1, 12'd4095, 12'd4095);
        write_reg(REG_UNUSED, 12'hABC);
        send_beat(8'd1,   8'd255, 8'd255, 8'd255);
        send_beat(8'd200, 8'd3,   8'd5,   8'd6);
        random_beats(60);
        wait_idle();

        // Random golden settings; the first long phase also carries the
        // long receiver hold-off so that the unit backs up to its input.
        set_golden(GOLDEN_RED_RST, GOLDEN_BLUE_RST, GOLDEN_GREEN_RST);
        hold_request = 1'b1;
        random_beats(250);
        wait_idle();
        for (int p = 0; p < 4; p++)
        begin
            set_golden(GOLD_W'($urandom_range(0, 4095)), GOLD_W'($urandom_range(0, 4095)),
                       GOLD_W'($urandom_range(1, 4095)));
            random_beats(70);
            wait_idle();
        end

        // Closing stretch with no idling on either side.
        quiet_tail = 1'b1;
        set_golden(GOLD_W'($urandom_range(0, 4095)), GOLD_W'($urandom_range(0, 4095)),
                   GOLD_W'($urandom_range(1, 4095)));
        random_beats(100);
        wait_idle();

        $display("Run covered %0d calibration beats and %0d results, %0d of them faults,",
                 sb.beats_in, sb.beats_out, sb.faults_seen);
        $display("over reset, extreme and random golden settings with input backpressure.");
        if (sb.errors == 0 && sb.expected_gains.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/owbg_pkg.sv
rtl/core/owbg_queue.sv
rtl/core/owbg_div.sv
rtl/core/owbg_front.sv
rtl/core/owbg_back.sv
rtl/core/otp_white_balance_gain_unit.sv
test/otp_white_balance_gain_unit_tb.sv
